// ===== rtl/core/vrt_pkg.sv =====
// Shared types and constants for the voxel ray traversal block.
package vrt_pkg;

  typedef struct packed {
    logic               cmd;
    logic [5:0]         voxel_x;
    logic [5:0]         voxel_y;
    logic [5:0]         voxel_z;
    logic [5:0]         voxel_data;
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic signed [15:0] origin_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic [9:0]         max_distance;
  } vrt_in_t;

  typedef struct packed {
    logic               hit;
    logic signed [11:0] hit_x;
    logic signed [11:0] hit_y;
    logic signed [11:0] hit_z;
    logic [1:0]         normal_axis;
    logic               normal_negative;
    logic [5:0]         block_code;
    logic [9:0]         remaining_distance;
  } vrt_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_WRITE,
    ST_WALK
  } vrt_state_e;

  localparam logic       CMD_WRITE = 1'b0;
  localparam logic       CMD_CAST  = 1'b1;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic [1:0] CFG_SIZE_X = 2'd0;
  localparam logic [1:0] CFG_SIZE_Y = 2'd1;
  localparam logic [1:0] CFG_SIZE_Z = 2'd2;

  localparam int CELL_W     = 14;
  localparam int SETUP_LAST = 9;

endpackage

// ===== rtl/core/vrt_ram.sv =====
// Generic single-port RAM with registered read data.
module vrt_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 262144
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ===== rtl/core/voxel_ray_traversal.sv =====
// Voxel store with a grid-walking ray caster, top level.
//
// Usage: drive item_i and pulse start_i while busy_o is low; the item is
// taken at that edge and busy_o rises. cmd 0 stores one voxel code, cmd 1
// casts a ray. Exactly one result per item appears on result_o for one
// cycle, marked by done_o; the receiver cannot stall it.
// Sizes are written through cfg_we_i / cfg_idx_i / cfg_data_i while idle.
// Every item first runs a setup phase in which one shared multiplier
// forms the start address and the six crossing cross-products.
// A write then stores the code in the write state and raises done_o.
// A cast then walks at most max_distance voxel steps; the walk rate is
// one step per cycle, set by the single-port voxel RAM read that each
// step issues.
// A new item may be started in the cycle done_o is high.
// Reset clears the controller and sets all sizes to 64; voxel contents
// are undefined until written.
module voxel_ray_traversal
  import vrt_pkg::*;
#(
  parameter int AXIS_SIZE     = 64,
  parameter int FRACTION_BITS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  vrt_in_t    item_i,
  output logic       done_o,
  output vrt_out_t   result_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [6:0] cfg_data_i
);

  localparam int DEPTH = AXIS_SIZE * AXIS_SIZE * AXIS_SIZE;
  localparam int AD_W  = $clog2(DEPTH);
  localparam int ES_W  = $clog2(AXIS_SIZE + 1);
  localparam int SZ_W  = (ES_W > 7) ? ES_W : 7;
  localparam int N_W   = FRACTION_BITS + 1;
  localparam int P_W   = FRACTION_BITS + 11 + 16;
  localparam int MA_W  = (AD_W > 16) ? AD_W : 16;
  localparam int MB_W  = (N_W > 2 * ES_W) ? N_W : 2 * ES_W;
  localparam int MP_W  = MA_W + MB_W;
  localparam int K_W   = $clog2(SETUP_LAST + 1);

  vrt_state_e state_q, state_d;

  logic [6:0]              size_q [3];
  logic [ES_W-1:0]         eff [3];
  logic [K_W-1:0]          k_q, k_d;
  logic                    cmd_q, cmd_d;
  logic [5:0]              data_q, data_d;
  logic signed [CELL_W-1:0] cell_q [3];
  logic signed [CELL_W-1:0] cell_d [3];
  logic [N_W-1:0]          n_q [3];
  logic [N_W-1:0]          n_d [3];
  logic [15:0]             d_q [3];
  logic [15:0]             d_d [3];
  logic                    neg_q [3];
  logic                    neg_d [3];
  logic [9:0]              budget_q, budget_d;
  logic [AD_W-1:0]         sxsy_q, sxsy_d;
  logic [AD_W-1:0]         addr_q, addr_d;
  logic [MP_W-1:0]         mult_q;
  logic [MA_W-1:0]         mul_a;
  logic [MB_W-1:0]         mul_b;
  logic [P_W-1:0]          p_q [6];
  logic [P_W-1:0]          p_d [6];
  logic [1:0]              axis_q, axis_d;
  logic                    negf_q, negf_d;
  logic                    rd_pend_q, rd_pend_d;
  logic                    inb_q, inb_d;
  logic                    done_q, done_d;
  vrt_out_t                out_q, out_d;
  logic [5:0]              rdata;
  logic                    ram_we;
  logic [AD_W-1:0]         ram_addr;
  logic                    f01, f02, f12;
  logic [1:0]              sel;
  logic [5:0]              code_w;
  logic signed [15:0]      org [3];
  logic signed [15:0]      dir [3];

  function automatic logic in_vol(input logic signed [CELL_W-1:0] c,
                                  input logic [ES_W-1:0] e);
    in_vol = !c[CELL_W-1] && ($unsigned(c) < CELL_W'(e));
  endfunction

  // pair index order: 01 10 02 20 12 21
  function automatic logic farther(input logic [15:0] da, input logic [15:0] db,
                                   input logic [P_W-1:0] pab,
                                   input logic [P_W-1:0] pba);
    if (da == '0) begin
      farther = (db != '0);
    end else if (db == '0) begin
      farther = 1'b0;
    end else begin
      farther = pab > pba;
    end
  endfunction

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [SZ_W-1:0] ext;
      ext = SZ_W'(size_q[i]);
      eff[i] = (ext > SZ_W'(AXIS_SIZE)) ? ES_W'(AXIS_SIZE) : ES_W'(ext);
    end
  end

  assign org[0] = item_i.origin_x;
  assign org[1] = item_i.origin_y;
  assign org[2] = item_i.origin_z;
  assign dir[0] = item_i.dir_x;
  assign dir[1] = item_i.dir_y;
  assign dir[2] = item_i.dir_z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q[0] <= 7'd64;
      size_q[1] <= 7'd64;
      size_q[2] <= 7'd64;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SIZE_X: size_q[0] <= cfg_data_i;
        CFG_SIZE_Y: size_q[1] <= cfg_data_i;
        CFG_SIZE_Z: size_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (k_q)
      K_W'(0): begin
        mul_a = MA_W'(eff[0]);
        mul_b = MB_W'(eff[1]);
      end
      K_W'(1): begin
        mul_a = MA_W'(AD_W'(cell_q[1]));
        mul_b = MB_W'(eff[0]);
      end
      K_W'(2): begin
        mul_a = MA_W'(AD_W'(cell_q[2]));
        mul_b = MB_W'(sxsy_q);
      end
      K_W'(3): begin mul_a = MA_W'(d_q[1]); mul_b = MB_W'(n_q[0]); end
      K_W'(4): begin mul_a = MA_W'(d_q[0]); mul_b = MB_W'(n_q[1]); end
      K_W'(5): begin mul_a = MA_W'(d_q[2]); mul_b = MB_W'(n_q[0]); end
      K_W'(6): begin mul_a = MA_W'(d_q[0]); mul_b = MB_W'(n_q[2]); end
      K_W'(7): begin mul_a = MA_W'(d_q[2]); mul_b = MB_W'(n_q[1]); end
      K_W'(8): begin mul_a = MA_W'(d_q[1]); mul_b = MB_W'(n_q[2]); end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    mult_q <= mul_a * mul_b;
  end

  // axis choice: lower axis wins ties
  always_comb begin
    f01 = farther(d_q[0], d_q[1], p_q[0], p_q[1]);
    f02 = farther(d_q[0], d_q[2], p_q[2], p_q[3]);
    f12 = farther(d_q[1], d_q[2], p_q[4], p_q[5]);
    sel = f01 ? (f12 ? AXIS_Z : AXIS_Y) : (f02 ? AXIS_Z : AXIS_X);
    code_w = (rd_pend_q && inb_q) ? rdata : 6'd0;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (start_i) state_d = ST_SETUP;
      ST_SETUP: begin
        if (k_q == K_W'(SETUP_LAST)) begin
          state_d = (cmd_q == CMD_WRITE) ? ST_WRITE : ST_WALK;
        end
      end
      ST_WRITE: state_d = ST_IDLE;
      ST_WALK: begin
        if ((code_w != 6'd0) || (budget_q == 10'd0)) state_d = ST_IDLE;
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy_o   = (state_q != ST_IDLE);
    ram_we   = (state_q == ST_WRITE) && in_vol(cell_q[0], eff[0]) &&
               in_vol(cell_q[1], eff[1]) && in_vol(cell_q[2], eff[2]);
    ram_addr = (state_q == ST_WRITE) ? addr_q : addr_d;
  end

  // datapath
  always_comb begin
    k_d       = k_q;
    cmd_d     = cmd_q;
    data_d    = data_q;
    cell_d    = cell_q;
    n_d       = n_q;
    d_d       = d_q;
    neg_d     = neg_q;
    budget_d  = budget_q;
    sxsy_d    = sxsy_q;
    addr_d    = addr_q;
    p_d       = p_q;
    axis_d    = axis_q;
    negf_d    = negf_q;
    rd_pend_d = 1'b0;
    inb_d     = inb_q;
    done_d    = 1'b0;
    out_d     = out_q;
    unique case (state_q)
      ST_IDLE: begin
        k_d      = '0;
        cmd_d    = item_i.cmd;
        data_d   = item_i.voxel_data;
        budget_d = item_i.max_distance;
        axis_d   = AXIS_X;
        negf_d   = 1'b0;
        for (int i = 0; i < 3; i++) begin
          logic signed [15:0] fl;
          logic [N_W-1:0]     fr;
          fl       = org[i] >>> FRACTION_BITS;
          fr       = N_W'(org[i][FRACTION_BITS-1:0]);
          neg_d[i] = dir[i][15];
          d_d[i]   = dir[i][15] ? 16'(-dir[i]) : 16'(dir[i]);
          n_d[i]   = dir[i][15] ? fr : (N_W'(1) << FRACTION_BITS) - fr;
          cell_d[i] = CELL_W'(fl);
        end
        if (item_i.cmd == CMD_WRITE) begin
          cell_d[0] = CELL_W'(item_i.voxel_x);
          cell_d[1] = CELL_W'(item_i.voxel_y);
          cell_d[2] = CELL_W'(item_i.voxel_z);
        end
        addr_d = AD_W'(cell_d[0]);
      end
      ST_SETUP: begin
        k_d = k_q + K_W'(1);
        unique case (k_q)
          K_W'(1): sxsy_d = AD_W'(mult_q);
          K_W'(2), K_W'(3): addr_d = addr_q + AD_W'(mult_q);
          K_W'(4): p_d[0] = P_W'(mult_q);
          K_W'(5): p_d[1] = P_W'(mult_q);
          K_W'(6): p_d[2] = P_W'(mult_q);
          K_W'(7): p_d[3] = P_W'(mult_q);
          K_W'(8): p_d[4] = P_W'(mult_q);
          K_W'(9): p_d[5] = P_W'(mult_q);
          default: ;
        endcase
      end
      ST_WRITE: begin
        done_d = 1'b1;
        out_d  = '0;
      end
      ST_WALK: begin
        if (code_w != 6'd0) begin
          done_d                   = 1'b1;
          out_d.hit                = 1'b1;
          out_d.block_code         = code_w;
          out_d.remaining_distance = budget_q;
        end else if (budget_q == 10'd0) begin
          done_d                   = 1'b1;
          out_d.hit                = 1'b0;
          out_d.block_code         = 6'd0;
          out_d.remaining_distance = 10'd0;
        end else begin
          logic [AD_W-1:0] delta;
          unique case (sel)
            AXIS_Y: begin
              delta  = AD_W'(eff[0]);
              p_d[1] = p_q[1] + (P_W'(d_q[0]) << FRACTION_BITS);
              p_d[4] = p_q[4] + (P_W'(d_q[2]) << FRACTION_BITS);
            end
            AXIS_Z: begin
              delta  = sxsy_q;
              p_d[3] = p_q[3] + (P_W'(d_q[0]) << FRACTION_BITS);
              p_d[5] = p_q[5] + (P_W'(d_q[1]) << FRACTION_BITS);
            end
            default: begin
              delta  = AD_W'(1);
              p_d[0] = p_q[0] + (P_W'(d_q[1]) << FRACTION_BITS);
              p_d[2] = p_q[2] + (P_W'(d_q[2]) << FRACTION_BITS);
            end
          endcase
          if (neg_q[sel]) begin
            cell_d[sel] = cell_q[sel] - CELL_W'(1);
            addr_d      = addr_q - delta;
          end else begin
            cell_d[sel] = cell_q[sel] + CELL_W'(1);
            addr_d      = addr_q + delta;
          end
          budget_d  = budget_q - 10'd1;
          axis_d    = sel;
          negf_d    = neg_q[sel];
          rd_pend_d = 1'b1;
          inb_d     = in_vol(cell_d[0], eff[0]) && in_vol(cell_d[1], eff[1]) &&
                      in_vol(cell_d[2], eff[2]);
        end
        out_d.hit_x           = cell_q[0][11:0];
        out_d.hit_y           = cell_q[1][11:0];
        out_d.hit_z           = cell_q[2][11:0];
        out_d.normal_axis     = axis_q;
        out_d.normal_negative = negf_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      k_q       <= '0;
      rd_pend_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      k_q       <= k_d;
      rd_pend_q <= rd_pend_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    data_q   <= data_d;
    cell_q   <= cell_d;
    n_q      <= n_d;
    d_q      <= d_d;
    neg_q    <= neg_d;
    budget_q <= budget_d;
    sxsy_q   <= sxsy_d;
    addr_q   <= addr_d;
    p_q      <= p_d;
    axis_q   <= axis_d;
    negf_q   <= negf_d;
    inb_q    <= inb_d;
    out_q    <= out_d;
  end

  vrt_ram #(
    .WIDTH(6),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(data_q),
    .rdata_o(rdata)
  );

  assign done_o   = done_q;
  assign result_o = out_q;

endmodule
